// ===== hdl/fbpa_pkg.sv =====
// Shared types and constants for the fixed-size block pool allocator.
// Used by fbpa_ctrl, fbpa_datapath, fixed_block_pool_allocator and fbpa_checker.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 32;

    // Fixed widths of the request, result and register fields
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int BSZ_W    = 5;
    localparam int ALIGN_W  = 4;
    localparam int TOTAL_W  = 7;
    localparam int CFG_IDX_W = 2;

    // Register values after reset
    localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd4096;
    localparam logic [BSZ_W-1:0]   BSZ_RST   = 5'd6;
    localparam logic [ALIGN_W-1:0] ALIGN_RST = 4'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_RST = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_POOL_EMPTY   = 3'd1,
        ST_NULL_ADDR    = 3'd2,
        ST_POOL_FULL    = 3'd3,
        ST_MISALIGNED   = 3'd4,
        ST_ALREADY_FREE = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_BSZ   = 2'd1,
        CFG_ALIGN = 2'd2,
        CFG_TOTAL = 2'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    pop_read;
        logic    pop_take;
        logic    take_unused;
        logic    scan_start;
        logic    scan_step;
        logic    push;
        logic    emit;
        t_status code;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_null;
        logic is_full;
        logic misaligned;
        logic stack_nonempty;
        logic unused_nonempty;
        logic stack_room;
        logic scan_done;
        logic hit;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/fbpa_ctrl.sv =====
// Request sequencer of the block pool allocator.
// Depends on fbpa_pkg for the command and status structs and the status codes.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  wire              i_kind,
    input  fbpa_pkg::t_sts   i_sts,
    output fbpa_pkg::t_cmd   o_cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_POP_WAIT,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    fbpa_pkg::t_status r_code,  n_code;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_kind ? S_CHECK : S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.stack_nonempty) begin
                    o_cmd.pop_read = 1'b1;
                    n_state = S_POP_WAIT;
                end else if (i_sts.unused_nonempty) begin
                    o_cmd.take_unused = 1'b1;
                    n_code  = fbpa_pkg::ST_OK;
                    n_state = S_EMIT;
                end else begin
                    n_code  = fbpa_pkg::ST_POOL_EMPTY;
                    n_state = S_EMIT;
                end
            end
            S_POP_WAIT: begin
                o_cmd.pop_take = 1'b1;
                n_code  = fbpa_pkg::ST_OK;
                n_state = S_EMIT;
            end
            S_CHECK: begin
                if (i_sts.is_null) begin
                    n_code  = fbpa_pkg::ST_NULL_ADDR;
                    n_state = S_EMIT;
                end else if (i_sts.is_full) begin
                    n_code  = fbpa_pkg::ST_POOL_FULL;
                    n_state = S_EMIT;
                end else if (i_sts.misaligned) begin
                    n_code  = fbpa_pkg::ST_MISALIGNED;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    n_state = S_EMIT;
                    if (i_sts.hit) begin
                        n_code = fbpa_pkg::ST_ALREADY_FREE;
                    end else if (i_sts.stack_room) begin
                        o_cmd.push = 1'b1;
                        n_code = fbpa_pkg::ST_OK;
                    end else begin
                        n_code = fbpa_pkg::ST_POOL_FULL;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= fbpa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fbpa_datapath.sv =====
// Datapath of the block pool allocator: registers, freed-block stack memory,
// scan counters and result registers. Depends on fbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_datapath #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  fbpa_pkg::t_cmd                   i_cmd,
    output fbpa_pkg::t_sts                   o_sts,
    input  wire [fbpa_pkg::ADDR_W-1:0]       i_block_address,
    input  wire                              i_cfg_valid,
    input  wire [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [fbpa_pkg::ADDR_W-1:0]       i_cfg_data,
    output logic                             o_done,
    output logic [fbpa_pkg::STATUS_W-1:0]    o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]      o_granted_address,
    output logic [fbpa_pkg::COUNT_W-1:0]     o_available_count
);

    localparam int AW = ADDR_BITS;
    localparam int DW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    // Configuration registers
    logic [fbpa_pkg::ADDR_W-1:0]  r_base;
    logic [fbpa_pkg::BSZ_W-1:0]   r_bsz;
    logic [fbpa_pkg::ALIGN_W-1:0] r_align;
    logic [fbpa_pkg::TOTAL_W-1:0] r_total;

    // Pool state
    logic [CW-1:0] r_depth;
    logic [CW-1:0] r_next;
    logic [AW-1:0] r_mem [MAX_BLOCKS];
    logic [AW-1:0] r_rd_data;

    // Request and scan registers
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_grant;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_uidx;
    logic [AW-1:0] r_ublk;
    logic          r_sv;
    logic          r_hit;

    logic [CW-1:0] eff_total;
    logic [CW-1:0] unused_cnt;
    logic [CW:0]   avail;
    logic [CW-1:0] depth_m1;
    logic [DW-1:0] rd_addr;
    logic [AW-1:0] stride;
    logic [AW-1:0] next_blk;
    logic [AW-1:0] amask;
    logic          stack_live;
    logic          unused_live;

    assign eff_total  = (int'(r_total) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(r_total);
    assign unused_cnt = (r_next < eff_total) ? (eff_total - r_next) : '0;
    assign avail      = {1'b0, r_depth} + {1'b0, unused_cnt};
    assign depth_m1   = r_depth - CW'(1);
    assign stride     = AW'(1) << r_bsz;
    assign next_blk   = AW'(r_base) + (AW'(r_next) << r_bsz);
    assign amask      = (AW'(1) << r_align) - AW'(1);
    assign stack_live = (r_idx < r_depth);
    assign unused_live = (r_uidx < eff_total);
    assign rd_addr    = i_cmd.pop_read ? depth_m1[DW-1:0] : r_idx[DW-1:0];

    always_comb begin
        o_sts.is_null         = (r_addr == '0);
        o_sts.is_full         = (avail >= {1'b0, eff_total});
        o_sts.misaligned      = |(r_addr & amask);
        o_sts.stack_nonempty  = (r_depth != '0);
        o_sts.unused_nonempty = (unused_cnt != '0);
        o_sts.stack_room      = (int'(r_depth) < MAX_BLOCKS);
        o_sts.scan_done       = !stack_live && !unused_live && !r_sv;
        o_sts.hit             = r_hit;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= fbpa_pkg::BASE_RST;
            r_bsz   <= fbpa_pkg::BSZ_RST;
            r_align <= fbpa_pkg::ALIGN_RST;
            r_total <= fbpa_pkg::TOTAL_RST;
        end else if (i_cfg_valid) begin
            unique case (fbpa_pkg::t_cfg_idx'(i_cfg_index))
                fbpa_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                fbpa_pkg::CFG_BSZ:   r_bsz   <= i_cfg_data[fbpa_pkg::BSZ_W-1:0];
                fbpa_pkg::CFG_ALIGN: r_align <= i_cfg_data[fbpa_pkg::ALIGN_W-1:0];
                fbpa_pkg::CFG_TOTAL: r_total <= i_cfg_data[fbpa_pkg::TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_depth[DW-1:0]] <= r_addr;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Pool state and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_next  <= '0;
            r_sv    <= 1'b0;
            r_hit   <= 1'b0;
            r_idx   <= '0;
            r_uidx  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.emit;
            if (i_cmd.pop_read) begin
                r_depth <= depth_m1;
            end else if (i_cmd.push) begin
                r_depth <= r_depth + CW'(1);
            end
            if (i_cmd.take_unused) begin
                r_next <= r_next + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx  <= '0;
                r_uidx <= r_next;
                r_sv   <= 1'b0;
                r_hit  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_sv <= stack_live;
                if (stack_live) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (unused_live) begin
                    r_uidx <= r_uidx + CW'(1);
                end
                if ((r_sv && (r_rd_data == r_addr)) ||
                    (unused_live && (r_ublk == r_addr))) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr  <= AW'(i_block_address);
            r_grant <= '0;
        end else if (i_cmd.pop_take) begin
            r_grant <= r_rd_data;
        end else if (i_cmd.take_unused) begin
            r_grant <= next_blk;
        end
        if (i_cmd.scan_start) begin
            r_ublk <= next_blk;
        end else if (i_cmd.scan_step) begin
            r_ublk <= r_ublk + stride;
        end
        if (i_cmd.emit) begin
            o_status          <= i_cmd.code;
            o_granted_address <= fbpa_pkg::ADDR_W'(r_grant);
            o_available_count <= fbpa_pkg::COUNT_W'(avail);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fixed_block_pool_allocator.sv =====
// An allocation passes the decide, pop-wait and emit states, and emit registers the result
// strobe (a never-used block skips pop-wait); a free rejected early goes from check to emit,
// else the scan first reads one stacked entry per cycle through the single memory port.
// Throughput: one request at a time; busy falls in the cycle that carries the result.
// The receiver cannot stall: each result shows for exactly one cycle on o_done.
// Reset (synchronous, active low) empties the pool and restores default registers.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Request channel
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_kind,
    input  wire [fbpa_pkg::ADDR_W-1:0]       i_block_address,
    // Result channel
    output logic                             o_done,
    output logic [fbpa_pkg::STATUS_W-1:0]    o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]      o_granted_address,
    output logic [fbpa_pkg::COUNT_W-1:0]     o_available_count,
    // Register write channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [fbpa_pkg::ADDR_W-1:0]       i_cfg_data
);

    fbpa_pkg::t_cmd cmd;
    fbpa_pkg::t_sts sts;

    // Register writes are taken on every cycle that i_cfg_valid is high, so the channel never pushes back.
    assign o_cfg_ready = 1'b1;

    // Sequencer: accept a request when idle, walk the checks, drive the datapath.
    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath: hold registers, the freed-block stack and the result registers.
    // A free request scans stacked entries and never-used blocks side by side,
    // one of each per cycle, and only then pushes.
    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_block_address   (i_block_address),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_available_count (o_available_count)
    );

endmodule

`default_nettype wire

// ===== hdl/fbpa_checker.sv =====
// Port-level checks for the block pool allocator, attached to the top level by bind.
// Depends on fbpa_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_port_checks (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              start,
    input wire                              busy,
    input wire                              o_done,
    input wire [fbpa_pkg::STATUS_W-1:0]     o_status,
    input wire [fbpa_pkg::ADDR_W-1:0]       o_granted_address
);

    // No result in the cycle after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result strobe one cycle after request");

    // The result cycle is an idle cycle
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy still high with result strobe");

    // Busy only rises after a start
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // A refused request grants nothing
    a_zero_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != fbpa_pkg::ST_OK)) |-> (o_granted_address == '0))
        else $error("nonzero grant on refused request");

endmodule

bind fixed_block_pool_allocator fbpa_port_checks u_fbpa_port_checks (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_granted_address (o_granted_address)
);

`default_nettype wire

// ===== tb/fbpa_tb_pkg.sv =====
// Request kinds shared by the pool allocator testbench top and its checker.
// Depends on nothing; compile it before fbpa_checker and the testbench top.
`timescale 1ns / 1ps

package fbpa_tb_pkg;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_kind;

endpackage

// ===== tb/fbpa_checker.sv =====
// Checker for the block pool allocator: keeps its own pool model, predicts each result.
// Depends on fbpa_pkg (field widths, status and register codes) and fbpa_tb_pkg.
`timescale 1ns / 1ps

module fbpa_checker
    import fbpa_pkg::*;
    import fbpa_tb_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire                  i_busy,
    input  wire                  i_kind,
    input  wire [ADDR_W-1:0]     i_block_address,
    input  wire                  i_done,
    input  wire [STATUS_W-1:0]   i_status,
    input  wire [ADDR_W-1:0]     i_granted_address,
    input  wire [COUNT_W-1:0]    i_available_count,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [ADDR_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   granted;
        logic [COUNT_W-1:0]  avail;
    } t_outcome;

    t_outcome outcome_q[$];

    logic [ADDR_W-1:0]  pool_base;
    logic [BSZ_W-1:0]   pool_bsz;
    logic [ALIGN_W-1:0] pool_align;
    logic [TOTAL_W-1:0] pool_total;
    logic [ADDR_W-1:0]  freed_blocks [MAX_BLOCKS];
    int                 freed_depth = 0;
    int                 next_fresh = 0;
    int                 fail_count = 0;

    function automatic int usable_blocks();
        return (int'(pool_total) > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_total);
    endfunction

    function automatic int fresh_blocks();
        int t;
        t = usable_blocks();
        return (next_fresh < t) ? t - next_fresh : 0;
    endfunction

    function automatic logic [ADDR_W-1:0] block_at(input int idx);
        logic [63:0] offset;
        offset = 64'(idx) << pool_bsz;
        return pool_base + offset[ADDR_W-1:0];
    endfunction

    // A block is free if it sits on the stack or has never been handed out.
    function automatic bit held_free(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < freed_depth; i++) begin
            if (freed_blocks[i] == addr) begin
                return 1'b1;
            end
        end
        for (int i = next_fresh; i < usable_blocks(); i++) begin
            if (block_at(i) == addr) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic clear_pool();
        pool_base   = BASE_RST;
        pool_bsz    = BSZ_RST;
        pool_align  = ALIGN_RST;
        pool_total  = TOTAL_RST;
        freed_depth = 0;
        next_fresh  = 0;
        outcome_q.delete();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_BASE:  pool_base  = data;
            CFG_BSZ:   pool_bsz   = data[BSZ_W-1:0];
            CFG_ALIGN: pool_align = data[ALIGN_W-1:0];
            CFG_TOTAL: pool_total = data[TOTAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_request(input logic kind, input logic [ADDR_W-1:0] addr);
        t_outcome          res;
        logic [ADDR_W-1:0] amask;
        int                avail;
        res.status  = ST_OK;
        res.granted = '0;
        avail = freed_depth + fresh_blocks();
        if (kind == REQ_ALLOC) begin
            if (freed_depth > 0) begin
                freed_depth--;
                res.granted = freed_blocks[freed_depth];
            end else if (fresh_blocks() > 0) begin
                res.granted = block_at(next_fresh);
                next_fresh++;
            end else begin
                res.status = ST_POOL_EMPTY;
            end
        end else begin
            amask = ~({ADDR_W{1'b1}} << pool_align);
            if (addr == '0) begin
                res.status = ST_NULL_ADDR;
            end else if (avail >= usable_blocks()) begin
                res.status = ST_POOL_FULL;
            end else if ((addr & amask) != '0) begin
                res.status = ST_MISALIGNED;
            end else if (held_free(addr)) begin
                res.status = ST_ALREADY_FREE;
            end else if (freed_depth < MAX_BLOCKS) begin
                freed_blocks[freed_depth] = addr;
                freed_depth++;
            end else begin
                res.status = ST_POOL_FULL;
            end
        end
        res.avail = COUNT_W'(freed_depth + fresh_blocks());
        outcome_q.push_back(res);
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            clear_pool();
        end else begin
            // Retire the result first: a new request may be taken on the same edge.
            if (i_done) begin
                if (outcome_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result: status %0d address %h count %0d",
                                 i_status, i_granted_address, i_available_count);
                    end
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status !== i_status || want.granted !== i_granted_address ||
                        want.avail !== i_available_count) begin
                        if (fail_count < 10) begin
                            $display("mismatch: status %0d/%0d address %h/%h count %0d/%0d",
                                     want.status, i_status, want.granted,
                                     i_granted_address, want.avail, i_available_count);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_start && !i_busy) begin
                predict_request(i_kind, i_block_address);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= outcome_q.size();
    end

endmodule

// ===== tb/fixed_block_pool_allocator_tb.sv =====
// Testbench top for fixed_block_pool_allocator: drives requests and register writes.
// Depends on fbpa_pkg, fbpa_tb_pkg and fbpa_checker, which predicts and compares.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;

    import fbpa_pkg::*;
    import fbpa_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int RANDOM_PHASES   = 11;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SHORT_PHASE     = 40;
    // Longest free scans the whole stack, so let that much time pass at the end.
    localparam int DRAIN_CYCLES    = MAX_BLOCKS_DEF + 8;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic                  i_kind          = REQ_ALLOC;
    logic [ADDR_W-1:0]     i_block_address = '0;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_W-1:0]     o_granted_address;
    logic [COUNT_W-1:0]    o_available_count;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_BASE;
    logic [ADDR_W-1:0]     i_cfg_data      = '0;

    int fail_count;
    int pending;
    int cycle_count;

    // Shadow of the registers, used to aim frees at block addresses and to size allocation runs
    logic [ADDR_W-1:0]  cur_base  = BASE_RST;
    logic [BSZ_W-1:0]   cur_bsz   = BSZ_RST;
    logic [ALIGN_W-1:0] cur_align = ALIGN_RST;
    logic [TOTAL_W-1:0] cur_total = TOTAL_RST;
    // Rough count of blocks handed out since the last register change
    int                 handed_hint = 0;

    fixed_block_pool_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_block_address   (i_block_address),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_available_count (o_available_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    fbpa_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_kind            (i_kind),
        .i_block_address   (i_block_address),
        .i_done            (o_done),
        .i_status          (o_status),
        .i_granted_address (o_granted_address),
        .i_available_count (o_available_count),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int usable_total();
        return (int'(cur_total) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(cur_total);
    endfunction

    function automatic logic [ADDR_W-1:0] pool_block(input int idx);
        logic [63:0] offset;
        offset = 64'(idx) << cur_bsz;
        return cur_base + offset[ADDR_W-1:0];
    endfunction

    // Mostly back to back, some short gaps, the odd long one.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // Free address for noise traffic: block addresses, near misses, null and junk.
    function automatic logic [ADDR_W-1:0] pick_free_address();
        int r;
        int span;
        r = $urandom_range(0, 99);
        span = usable_total() + 2;
        if (r < 55) begin
            return pool_block($urandom_range(0, span - 1));
        end
        if (r < 62) begin
            return '0;
        end
        if (r < 77) begin
            return pool_block($urandom_range(0, span - 1)) + $urandom_range(1, 7);
        end
        if (r < 85) begin
            return pool_block($urandom_range(0, span - 1)) + (ADDR_W'(1) << cur_align);
        end
        return $urandom();
    endfunction

    // Present a request and hold it until taken; leave start high if no gap follows.
    task automatic send_request(input t_req_kind kind, input logic [ADDR_W-1:0] addr,
                                input int gap);
        start           <= 1'b1;
        i_kind          <= kind;
        i_block_address <= addr;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and hold off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_BASE:  cur_base  = data;
            CFG_BSZ:   cur_bsz   = data[BSZ_W-1:0];
            CFG_ALIGN: cur_align = data[ALIGN_W-1:0];
            CFG_TOTAL: cur_total = data[TOTAL_W-1:0];
            default: ;
        endcase
        handed_hint = 0;
    endtask

    task automatic directed_checks();
        // Registers at reset: base 0x1000, 64-byte blocks, 8-byte alignment, 64 blocks.
        send_request(REQ_FREE,  32'h0000_0000, 1);  // null address wins over pool full
        send_request(REQ_FREE,  32'h0000_1000, 0);  // nothing handed out yet: pool full
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 0);  // first never-used block
        send_request(REQ_FREE,  32'h0000_1001, 2);  // misaligned
        send_request(REQ_FREE,  32'h0000_1040, 0);  // never-used block is already free
        send_request(REQ_FREE,  32'h0000_1000, 0);  // accepted, pushed
        send_request(REQ_FREE,  32'h0000_1000, 0);  // every block free again: pool full
        send_request(REQ_ALLOC, 32'h0000_0000, 0);  // pops the stacked block
        send_request(REQ_ALLOC, 32'h0000_0000, 0);  // next never-used block
        send_request(REQ_FREE,  32'hFFFF_FFFF, 0);  // misaligned at the top of the range
        send_request(REQ_FREE,  32'hFFFF_FFF8, 0);  // aligned foreign address: accepted
        send_request(REQ_ALLOC, 32'h0000_0000, 3);  // pops it straight back
        drain_results();

        // Empty pool setting
        write_register(CFG_TOTAL, 32'd0);
        send_request(REQ_ALLOC, 32'h0000_0000, 0);
        send_request(REQ_FREE,  32'h0000_1080, 0);
        send_request(REQ_FREE,  32'h0000_0000, 0);
        drain_results();

        // Oversized pool near the top of the address space: addresses wrap through zero
        write_register(CFG_BASE,  32'hFFFF_FFC0);
        write_register(CFG_BSZ,   32'd4);
        write_register(CFG_ALIGN, 32'd0);
        write_register(CFG_TOTAL, 32'd127);
        repeat (4) send_request(REQ_ALLOC, $urandom(), 0);
        send_request(REQ_FREE,  32'h0000_0000, 0);
        send_request(REQ_FREE,  32'hFFFF_FFE1, 0);
        drain_results();

        // Largest stride and alignment this bench uses, state kept across the change
        write_register(CFG_BSZ,   32'd16);
        write_register(CFG_ALIGN, 32'd12);
        write_register(CFG_TOTAL, 32'd64);
        send_request(REQ_ALLOC, 32'h0000_0000, 0);
        send_request(REQ_ALLOC, 32'h0000_0000, 0);
        send_request(REQ_FREE,  32'h0005_FFC0, 0);
        drain_results();
    endtask

    task automatic configure_phase(input int phase);
        logic [ADDR_W-1:0] base;
        int                bsz;
        int                align;
        int                total;
        int                r;
        case (phase)
            0: begin
                base = BASE_RST; bsz = 6; align = 3; total = 64;
            end
            1: begin
                base = '0; bsz = 0; align = 0; total = 1;
            end
            2: begin
                base = 32'hFFFF_FFFF; bsz = 16; align = 12; total = 127;
            end
            3: begin
                base = 32'h8000_0000; bsz = 3; align = 3; total = 8;
            end
            4: begin
                base = 32'h0001_0000; bsz = 12; align = 12; total = 0;
            end
            default: begin
                bsz   = $urandom_range(0, 16);
                align = $urandom_range(0, 12);
                if ($urandom_range(0, 3) != 0 && align > bsz) begin
                    align = bsz;
                end
                base = $urandom();
                if ($urandom_range(0, 4) != 0) begin
                    base = base & ({ADDR_W{1'b1}} << align);
                end
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    total = $urandom_range(1, 16);
                end else if (r < 90) begin
                    total = $urandom_range(17, 64);
                end else begin
                    total = $urandom_range(65, 127);
                end
            end
        endcase
        write_register(CFG_BASE,  base);
        write_register(CFG_BSZ,   ADDR_W'(bsz));
        write_register(CFG_ALIGN, ADDR_W'(align));
        write_register(CFG_TOTAL, ADDR_W'(total));
    endtask

    task automatic run_traffic(input int quota);
        int sent;
        int burst;
        int frees;
        int reach;
        bit steady;
        sent   = 0;
        steady = ($urandom_range(0, 4) == 0);
        while (sent < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                // Allocate a run of blocks, then hand back blocks from the used range
                burst = $urandom_range(1, usable_total() + 2);
                repeat (burst) begin
                    send_request(REQ_ALLOC, $urandom(), pick_gap(steady));
                    if (handed_hint < usable_total()) begin
                        handed_hint++;
                    end
                    sent++;
                end
                frees = $urandom_range(1, burst + 1);
                repeat (frees) begin
                    reach = (handed_hint > 0) ? handed_hint : 1;
                    send_request(REQ_FREE, pool_block($urandom_range(0, reach)),
                                 pick_gap(steady));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_request(REQ_ALLOC, $urandom(), pick_gap(steady));
                    end else begin
                        send_request(REQ_FREE, pick_free_address(), pick_gap(steady));
                    end
                    sent++;
                end
            end
            // Now and then let the pipeline run dry before carrying on
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end
            if ($urandom_range(0, 6) == 0) begin
                steady = !steady;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();

        // Registers only change with the block idle and every result back
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            configure_phase(phase);
            run_traffic((phase == 4) ? SHORT_PHASE : ITEMS_PER_PHASE);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
